/* hdl/blc_pkg.sv */
// ---------------------------------------------------------------------------
// blc_pkg
// Shared constants and controller/datapath command types for the binary
// blob line classifier.
// ---------------------------------------------------------------------------
package blc_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int MAX_HEIGHT    = 64;

    localparam int ROW_W  = 64;
    localparam int DIM_W  = 7;
    localparam int AREA_W = 13;
    localparam int CNT_W  = 7;
    localparam int LEN_W  = 7;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd10;

    // one run-test step per bit of min_line_length
    localparam int RUN_STEPS = LEN_W;
    localparam int STEP_W    = $clog2(RUN_STEPS);

    localparam int MIN_DIM      = 5;
    localparam int AREA_RATIO   = 50;
    localparam int ASPECT_RATIO = 10;
    localparam int CENTRE_RATIO = 10;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr above the byte offset
    localparam logic REG_MIN_LINE_LENGTH = 1'b0;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [STEP_W-1:0] k;
        logic              scan;
        logic              decide;
    } t_dp_cmd;

    typedef struct packed {
        logic final_row;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

/* hdl/blc_ctrl.sv */
// ---------------------------------------------------------------------------
// blc_ctrl
// Sequencer: takes a row word, runs the run-length steps, walks the column
// counts on the final row and hands the decision to the output register.
// ---------------------------------------------------------------------------
module blc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  blc_pkg::t_dp_status  i_status,
    output blc_pkg::t_dp_cmd     o_cmd
);
    import blc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_k, n_k;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        o_cmd        = '0;
        o_cmd.k      = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_k        = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                n_k        = r_k + STEP_W'(1);
                if (r_k == STEP_W'(RUN_STEPS - 1)) begin
                    n_state = i_status.final_row ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

endmodule

/* hdl/blc_dp.sv */
// ---------------------------------------------------------------------------
// blc_dp
// Column counters, long-run detector, tallest-column walk and line tests,
// with the registered result.
// ---------------------------------------------------------------------------
module blc_dp #(
    parameter int MAX_WIDTH = blc_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  blc_pkg::t_dp_cmd             i_cmd,
    output blc_pkg::t_dp_status          o_status,
    input  logic [blc_pkg::ROW_W-1:0]    i_row_pixels,
    input  logic [blc_pkg::DIM_W-1:0]    i_blob_width,
    input  logic [blc_pkg::DIM_W-1:0]    i_blob_height,
    input  logic [blc_pkg::AREA_W-1:0]   i_blob_area,
    input  logic                         i_first_row,
    input  logic                         i_final_row,
    input  logic [blc_pkg::LEN_W-1:0]    i_min_line_length,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_is_line
);
    import blc_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SQ_W    = 2 * DIM_W;
    localparam int AXR_W   = AREA_W + 6;
    localparam int TEN_W   = DIM_W + 4;

    logic [CNT_W-1:0]     r_cnt [MAX_WIDTH];
    logic [CNT_W-1:0]     n_cnt [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] row_m;
    logic [DIM_W-1:0]     weff_in;

    logic [MAX_WIDTH-1:0] r_p, r_x, p_next, x_next;
    logic [LEN_W-1:0]     r_m, m_next, step_len;
    logic                 r_long_run;

    logic [DIM_W-1:0]     r_w, r_h, r_weff;
    logic [AREA_W-1:0]    r_area;
    logic                 r_final;

    logic [COL_W-1:0]     r_j, r_best_col;
    logic [CNT_W-1:0]     r_best;

    logic                 r_out_valid, r_is_line;

    logic [SQ_W-1:0]      w_sq;
    logic [AXR_W-1:0]     area_x;
    logic [TEN_W-1:0]     h_x, left_x, right_x;
    logic [DIM_W-1:0]     left, right;
    logic                 pass;

    // pixels at or beyond the effective width are dropped
    assign weff_in = (i_blob_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : i_blob_width;

    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            row_m[c] = i_row_pixels[c] & (DIM_W'(c) < weff_in);
        end
    end

    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            n_cnt[c] = i_first_row ? '0 : r_cnt[c];
            if (row_m[c] && n_cnt[c] != CNT_MAX) begin
                n_cnt[c] = n_cnt[c] + CNT_W'(1);
            end
        end
    end

    // binary build-up of the window test: x marks starts of r_m set pixels
    assign step_len = LEN_W'(1) << i_cmd.k;
    assign p_next   = r_p & (r_p >> step_len);
    assign x_next   = i_min_line_length[i_cmd.k] ? (r_x & (r_p >> r_m)) : r_x;
    assign m_next   = r_m + (i_min_line_length[i_cmd.k] ? step_len : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_WIDTH; c++) begin
                r_cnt[c] <= '0;
            end
            r_long_run <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                for (int c = 0; c < MAX_WIDTH; c++) begin
                    r_cnt[c] <= n_cnt[c];
                end
                if (i_first_row) begin
                    r_long_run <= 1'b0;
                end
            end else if (i_cmd.scan) begin
                // full rotation over the walk leaves the counts in place
                for (int c = 0; c < MAX_WIDTH - 1; c++) begin
                    r_cnt[c] <= r_cnt[c+1];
                end
                r_cnt[MAX_WIDTH-1] <= r_cnt[0];
            end
            if (i_cmd.step && i_cmd.k == STEP_W'(RUN_STEPS - 1) && x_next != '0) begin
                r_long_run <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p      <= row_m;
            r_x      <= '1;
            r_m      <= '0;
            r_w      <= i_blob_width;
            r_h      <= i_blob_height;
            r_area   <= i_blob_area;
            r_weff   <= weff_in;
            r_final  <= i_final_row;
            r_j      <= '0;
            r_best   <= '0;
            r_best_col <= '0;
        end else begin
            if (i_cmd.step) begin
                r_p <= p_next;
                r_x <= x_next;
                r_m <= m_next;
            end
            if (i_cmd.scan) begin
                if (DIM_W'(r_j) < r_weff && r_cnt[0] > r_best) begin
                    r_best     <= r_cnt[0];
                    r_best_col <= r_j;
                end
                r_j <= r_j + COL_W'(1);
            end
        end
    end

    assign w_sq    = SQ_W'(r_w) * SQ_W'(r_w);
    assign area_x  = AXR_W'(r_area) * AXR_W'(AREA_RATIO);
    assign h_x     = TEN_W'(r_h) * TEN_W'(ASPECT_RATIO);
    assign left    = DIM_W'(r_best_col);
    assign right   = r_w - left;
    assign left_x  = TEN_W'(left) * TEN_W'(CENTRE_RATIO);
    assign right_x = TEN_W'(right) * TEN_W'(CENTRE_RATIO);

    assign pass = (r_w >= DIM_W'(MIN_DIM)) && (r_h >= DIM_W'(MIN_DIM))
                && (r_w <= DIM_W'(MAX_WIDTH)) && (r_h <= DIM_W'(MAX_HEIGHT))
                && (r_w >= i_min_line_length)
                && (AXR_W'(w_sq) >= area_x)
                && (TEN_W'(r_w) >= h_x)
                && r_long_run
                && (left_x >= TEN_W'(right))
                && (right_x >= TEN_W'(left));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_is_line <= pass;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_is_line          = r_is_line;
    assign o_status.final_row = r_final;
    assign o_status.scan_last = (r_j == COL_W'(MAX_WIDTH - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

/* hdl/binary_blob_line_classifier.sv */
// sequence: a row word is loaded at its accepting edge, then 7 run-test steps follow (one per
//   bit of min_line_length); ready is high again after the last step unless the row is final
// final row: the column counts are then walked by rotation, one column a cycle, and
//   is_line is registered once the walk is done and the result register is free
// a new row word is taken only when the previous one is done; a stalled is_line holds it off
// reset: synchronous, active low; clears counts, run flag, handshakes, min_line_length to 10
// ---------------------------------------------------------------------------
// binary_blob_line_classifier
// Classifies a row-streamed binary blob as a thin horizontal line.
// ---------------------------------------------------------------------------
module binary_blob_line_classifier #(
    parameter int MAX_WIDTH = blc_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [blc_pkg::ROW_W-1:0]       i_row_pixels,
    input  logic [blc_pkg::DIM_W-1:0]       i_blob_width,
    input  logic [blc_pkg::DIM_W-1:0]       i_blob_height,
    input  logic [blc_pkg::AREA_W-1:0]      i_blob_area,
    input  logic                            i_first_row,
    input  logic                            i_final_row,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_is_line,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [blc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [blc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [blc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import blc_pkg::*;

    logic [LEN_W-1:0] r_min_line_length;
    logic             reg_hit;
    t_dp_cmd          cmd;
    t_dp_status       status;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_MIN_LINE_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_line_length <= LEN_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_min_line_length <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = reg_hit ? APB_DATA_W'(r_min_line_length) : '0;

    blc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    blc_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_row_pixels      (i_row_pixels),
        .i_blob_width      (i_blob_width),
        .i_blob_height     (i_blob_height),
        .i_blob_area       (i_blob_area),
        .i_first_row       (i_first_row),
        .i_final_row       (i_final_row),
        .i_min_line_length (r_min_line_length),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_is_line         (o_is_line)
    );

endmodule

/* hdl/blc_checker.sv */
// ---------------------------------------------------------------------------
// blc_checker
// Port-level checks on the line classifier, bound to the top level.
// ---------------------------------------------------------------------------
module blc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_is_line,
    input logic                            psel,
    input logic                            pwrite,
    input logic [blc_pkg::APB_DATA_W-1:0]  prdata
);
    import blc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_is_line))
        else $error("result word dropped or changed while stalled");

    // a row word keeps the block busy for its run-test steps
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready high in the cycle after a row word");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_prdata_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite |-> prdata[APB_DATA_W-1:LEN_W] == '0)
        else $error("read data wider than the register");

endmodule

bind binary_blob_line_classifier blc_checker u_blc_checker (.*);

/* verif/tb_binary_blob_line_classifier.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_binary_blob_line_classifier
// Streams blob rows into the line classifier and checks every is_line word
// against a row-by-row model of the column counts, the long-run flag and the
// final decision. The register is exercised over several settings from 0 up
// to its 7-bit maximum, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb_binary_blob_line_classifier;
    import blc_pkg::*;

    localparam int SETTLE_CYCLES   = 2 * (9 + MAX_WIDTH_DEF);
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam logic [APB_ADDR_W-1:0] MIN_LEN_ADDR = {REG_MIN_LINE_LENGTH, 2'b00};

    typedef struct packed {
        logic [ROW_W-1:0]  pixels;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [AREA_W-1:0] area;
        logic              is_first;
        logic              is_final;
    } t_row_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [ROW_W-1:0]       i_row_pixels;
    logic [DIM_W-1:0]       i_blob_width;
    logic [DIM_W-1:0]       i_blob_height;
    logic [AREA_W-1:0]      i_blob_area;
    logic                   i_first_row;
    logic                   i_final_row;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_is_line;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // model state
    logic [CNT_W-1:0] col_counts [MAX_WIDTH_DEF];
    logic             run_seen_model;
    logic [LEN_W-1:0] min_len_model;
    bit               pending_verdicts [$];

    int  mismatches = 0;
    int  rows_sent = 0;
    int  verdicts_seen = 0;
    int  lines_seen = 0;
    int  settings_used = 1;
    int  stuck_cycles = 0;
    bit  sender_gaps = 1'b1;
    bit  quiet_tail = 1'b0;
    bit  hold_off_req = 1'b0;

    binary_blob_line_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_row_pixels  (i_row_pixels),
        .i_blob_width  (i_blob_width),
        .i_blob_height (i_blob_height),
        .i_blob_area   (i_blob_area),
        .i_first_row   (i_first_row),
        .i_final_row   (i_final_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_is_line     (o_is_line),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at %0t: %s, got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [ROW_W-1:0] width_bits(int w);
        if (w <= 0)
            return '0;
        if (w >= ROW_W)
            return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [ROW_W-1:0] run_bits(int start, int len);
        return width_bits(len) << start;
    endfunction

    function automatic t_row_word mk_row(logic [ROW_W-1:0] px, int w, int h, int area,
                                         bit f, bit l);
        t_row_word r;
        r.pixels   = px;
        r.width    = w[DIM_W-1:0];
        r.height   = h[DIM_W-1:0];
        r.area     = area[AREA_W-1:0];
        r.is_first = f;
        r.is_final = l;
        return r;
    endfunction

    function automatic int longest_set_run(logic [ROW_W-1:0] bits);
        int run;
        int best;
        run = 0;
        best = 0;
        for (int c = 0; c < ROW_W; c++) begin
            if (bits[c]) begin
                run++;
                if (run > best)
                    best = run;
            end else begin
                run = 0;
            end
        end
        return best;
    endfunction

    function automatic bit line_verdict(int w, int h, int area);
        int tallest;
        int col;
        int left;
        int right;
        tallest = 0;
        col = 0;
        if (w < MIN_DIM || h < MIN_DIM)
            return 1'b0;
        if (w > MAX_WIDTH_DEF || h > MAX_HEIGHT)
            return 1'b0;
        if (w < int'(min_len_model))
            return 1'b0;
        if (w * w < area * AREA_RATIO)
            return 1'b0;
        if (w < h * ASPECT_RATIO)
            return 1'b0;
        if (!run_seen_model)
            return 1'b0;
        // first tallest column wins
        for (int c = 0; c < w && c < MAX_WIDTH_DEF; c++) begin
            if (int'(col_counts[c]) > tallest) begin
                tallest = col_counts[c];
                col = c;
            end
        end
        left = col;
        right = w - col;
        if (left * CENTRE_RATIO < right)
            return 1'b0;
        if (right * CENTRE_RATIO < left)
            return 1'b0;
        return 1'b1;
    endfunction

    // returns 1 when the row closes a blob; verdict then holds the decision
    function automatic bit absorb_row(t_row_word r, output bit verdict);
        int weff;
        logic [ROW_W-1:0] px;
        weff = (r.width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(r.width);
        if (r.is_first) begin
            foreach (col_counts[c])
                col_counts[c] = '0;
            run_seen_model = 1'b0;
        end
        px = r.pixels & width_bits(weff);
        for (int c = 0; c < weff; c++) begin
            if (px[c] && col_counts[c] != CNT_MAX)
                col_counts[c] = col_counts[c] + 1'b1;
        end
        if (longest_set_run(px) >= int'(min_len_model))
            run_seen_model = 1'b1;
        verdict = 1'b0;
        if (!r.is_final)
            return 1'b0;
        verdict = line_verdict(r.width, r.height, r.area);
        return 1'b1;
    endfunction

    task automatic send_row(t_row_word r);
        bit verdict;
        if (sender_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_row_pixels  <= r.pixels;
        i_blob_width  <= r.width;
        i_blob_height <= r.height;
        i_blob_area   <= r.area;
        i_first_row   <= r.is_first;
        i_final_row   <= r.is_final;
        do @(posedge i_clk); while (!o_in_ready);
        rows_sent++;
        if (absorb_row(r, verdict))
            pending_verdicts.push_back(verdict);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        // a trailing row without final_row may still be in its run test
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_min_line_length(int v);
        logic [APB_DATA_W-1:0] rd;
        wait_idle();
        apb_write(MIN_LEN_ADDR, v);
        min_len_model = v[LEN_W-1:0];
        settings_used++;
        // the bus idles between the write and the read-back
        @(posedge i_clk);
        apb_read(MIN_LEN_ADDR, rd);
        if (rd !== APB_DATA_W'(min_len_model))
            report_mismatch("min_line_length read-back", rd, min_len_model);
    endtask

    task automatic test_reset_value();
        logic [APB_DATA_W-1:0] rd;
        apb_read(MIN_LEN_ADDR, rd);
        if (rd !== APB_DATA_W'(LEN_RESET))
            report_mismatch("min_line_length after reset", rd, LEN_RESET);
    endtask

    task automatic test_directed_cases();
        // field extremes, one row each
        send_row(mk_row('1, 64, 5, 0, 1, 1));
        send_row(mk_row('0, 64, 64, 4096, 1, 1));
        send_row(mk_row('1, 127, 5, 0, 1, 1));
        send_row(mk_row('1, 60, 127, 0, 1, 1));
        send_row(mk_row('1, 0, 5, 0, 1, 1));
        send_row(mk_row(64'h1, 1, 1, 1, 1, 1));
        send_row(mk_row('0, 4, 4, 8191, 1, 1));
        // clean line, area right on the limit
        send_row(mk_row(64'd1 << 30, 60, 5, 72, 1, 0));
        send_row(mk_row(64'd1 << 30, 60, 5, 72, 0, 0));
        send_row(mk_row(run_bits(5, 50), 60, 5, 72, 0, 0));
        send_row(mk_row(64'd1 << 30, 60, 5, 72, 0, 0));
        send_row(mk_row(64'd1 << 30, 60, 5, 72, 0, 1));
        // one pixel too much area
        send_row(mk_row(run_bits(5, 50), 60, 5, 73, 1, 0));
        send_row(mk_row(64'd1 << 30, 60, 5, 73, 0, 1));
        // no first row: counts carry over from the blob before
        send_row(mk_row(64'd1 << 31, 60, 5, 72, 0, 0));
        send_row(mk_row(64'd1 << 31, 60, 5, 72, 0, 0));
        send_row(mk_row(run_bits(5, 50), 60, 5, 72, 0, 1));
        // set pixels only beyond the width
        send_row(mk_row(~width_bits(10), 10, 5, 0, 1, 1));
        send_row(mk_row(~width_bits(55), 55, 5, 0, 1, 1));
        // aspect and area on the limit, run exactly min_line_length long
        send_row(mk_row(run_bits(20, 10), 50, 5, 50, 1, 0));
        send_row(mk_row(64'd1 << 25, 50, 5, 50, 0, 1));
    endtask

    task automatic test_zero_minimum();
        set_min_line_length(0);
        // the first row has no set pixels and the second a single one, yet the run test passes
        send_row(mk_row('0, 60, 5, 0, 1, 0));
        send_row(mk_row(64'd1 << 30, 60, 5, 0, 0, 1));
    endtask

    task automatic test_count_saturation();
        logic [ROW_W-1:0] px;
        set_min_line_length(10);
        for (int i = 0; i < 130; i++) begin
            px = (64'd1 << 30) | ({$urandom, $urandom} & {$urandom, $urandom});
            if (i == 5)
                px = px | run_bits(8, 40);
            send_row(mk_row(px, 60, 6, 10, i == 0, i == 129));
        end
    endtask

    task automatic test_input_backpressure();
        sender_gaps = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_row(mk_row({$urandom, $urandom}, $urandom_range(50, 64), 5, 20, 1, 1));
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_blobs(int n_rows);
        int target;
        int sel;
        int w;
        int h;
        int area;
        int nrows;
        int main_row;
        int drop;
        int s;
        int lo;
        int hi;
        logic [ROW_W-1:0] px;
        target = rows_sent + n_rows;
        while (rows_sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                // line-like blob: one long run plus a few pixels near the middle
                w = $urandom_range(46, 64);
                h = $urandom_range(4, 7);
                nrows = $urandom_range(1, 7);
                area = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, w * w / 50 + 2);
                main_row = $urandom_range(0, nrows - 1);
                drop = $urandom_range(0, 9);
                for (int i = 0; i < nrows; i++) begin
                    if (i == main_row) begin
                        s = $urandom_range(0, w / 3);
                        lo = (int'(min_len_model) > 2) ? int'(min_len_model) - 2 : 1;
                        hi = w - s;
                        if (lo > hi)
                            lo = hi;
                        px = run_bits(s, $urandom_range(lo, hi));
                    end else begin
                        px = 64'd1 << $urandom_range(w / 4, 3 * w / 4);
                    end
                    if ($urandom_range(0, 3) == 0)
                        px = px | (64'd1 << $urandom_range(0, w - 1));
                    if ($urandom_range(0, 4) == 0)
                        px = px | ({$urandom, $urandom} & ~width_bits(w));
                    // broken sequences: first or final flag left off now and then
                    send_row(mk_row(px, w, h, area, i == 0 && drop != 0,
                                    i == nrows - 1 && drop != 1));
                end
            end else if (sel < 80) begin
                w = $urandom_range(0, 127);
                h = $urandom_range(0, 127);
                area = $urandom_range(0, 8191);
                nrows = $urandom_range(1, 6);
                for (int i = 0; i < nrows; i++)
                    send_row(mk_row({$urandom, $urandom}, w, h, area, i == 0,
                                    i == nrows - 1));
            end else begin
                w = $urandom_range(0, 127);
                px = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                                 : run_bits($urandom_range(0, 20),
                                                            $urandom_range(0, 64));
                send_row(mk_row(px, w, $urandom_range(0, 127), $urandom_range(0, 8191),
                                1, 1));
            end
        end
    endtask

    task automatic test_quiet_tail();
        quiet_tail = 1'b1;
        test_random_blobs(80);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : receiver
        int n;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        bit want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("is_line word with no decision pending", o_is_line, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_is_line !== want)
                    report_mismatch("is_line", o_is_line, want);
                verdicts_seen++;
                if (want)
                    lines_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles with no transfer", stuck_cycles);
            $display("binary_blob_line_classifier verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_row_pixels  <= '0;
        i_blob_width  <= '0;
        i_blob_height <= '0;
        i_blob_area   <= '0;
        i_first_row   <= 1'b0;
        i_final_row   <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        foreach (col_counts[c])
            col_counts[c] = '0;
        run_seen_model = 1'b0;
        min_len_model = LEN_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_value();
        test_directed_cases();
        test_zero_minimum();
        test_random_blobs(250);
        set_min_line_length(MAX_WIDTH_DEF);
        test_random_blobs(250);
        set_min_line_length(1);
        test_random_blobs(250);
        set_min_line_length(127);
        test_random_blobs(100);
        test_count_saturation();
        test_input_backpressure();
        set_min_line_length($urandom_range(2, 63));
        test_random_blobs(250);
        set_min_line_length(LEN_RESET);
        test_random_blobs(250);
        test_quiet_tail();
        wait_idle();

        $display("covered %0d rows and %0d blob decisions, %0d of them lines,",
                 rows_sent, verdicts_seen, lines_seen);
        $display("across %0d min_line_length settings with stalls on both sides",
                 settings_used);
        if (mismatches == 0) begin
            $display("binary_blob_line_classifier verification clean");
        end else begin
            $display("binary_blob_line_classifier verification failed");
        end
        $finish;
    end

endmodule
